// ----- hdl/dpdd_pkg.sv -----
// ----------------------------------------------------------------------------
// dpdd_pkg
// Shared constants and types for the dual PID differential drive unit.
// ----------------------------------------------------------------------------
package dpdd_pkg;

    localparam int POS_WIDTH_DEF  = 24;
    localparam int GAIN_FRAC_DEF  = 8;
    localparam int GAIN_W         = 16;
    localparam int SUM_W          = 32;
    localparam int DRIVE_W        = 13;
    localparam int DRIVE_LIMIT    = 3072;
    localparam int LAT_TGT_RESET  = 200;
    localparam int CFG_IDX_W      = 3;
    localparam int PIPE_STAGES    = 5;

    localparam logic signed [SUM_W-1:0] SUM_HI = {1'b0, {(SUM_W-1){1'b1}}};
    localparam logic signed [SUM_W-1:0] SUM_LO = {1'b1, {(SUM_W-1){1'b0}}};

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_LAT_KP  = 3'd0,
        REG_LAT_KI  = 3'd1,
        REG_LAT_KD  = 3'd2,
        REG_TURN_KP = 3'd3,
        REG_TURN_KI = 3'd4,
        REG_TURN_KD = 3'd5,
        REG_LAT_TGT = 3'd6,
        REG_TURN_TGT = 3'd7
    } t_cfg_reg;

    // pipeline stage positions in the valid vector
    typedef enum int {
        STG_IN  = 0,
        STG_ERR = 1,
        STG_MUL = 2,
        STG_POW = 3,
        STG_OUT = 4
    } t_stage;

endpackage

// ----- hdl/dpdd_error.sv -----
// ----------------------------------------------------------------------------
// dpdd_error
// Error stage: lateral and turn errors, derivatives and saturating sums.
// Holds the controller state (last errors and error sums).
// ----------------------------------------------------------------------------
module dpdd_error
    import dpdd_pkg::*;
#(
    parameter int POSITION_WIDTH = POS_WIDTH_DEF
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_load,
    input  logic signed [POSITION_WIDTH-1:0]  i_left_pos,
    input  logic signed [POSITION_WIDTH-1:0]  i_right_pos,
    input  logic signed [POSITION_WIDTH-1:0]  i_lat_target,
    input  logic signed [POSITION_WIDTH-1:0]  i_turn_target,
    output logic signed [POSITION_WIDTH:0]    o_lat_err,
    output logic signed [POSITION_WIDTH+1:0]  o_lat_der,
    output logic signed [SUM_W-1:0]           o_lat_sum,
    output logic signed [POSITION_WIDTH+1:0]  o_turn_err,
    output logic signed [POSITION_WIDTH+2:0]  o_turn_der,
    output logic signed [SUM_W-1:0]           o_turn_sum
);

    localparam int P       = POSITION_WIDTH;
    localparam int LERR_W  = P + 1;
    localparam int LDER_W  = P + 2;
    localparam int TERR_W  = P + 2;
    localparam int TDER_W  = P + 3;
    localparam int SACC_W  = ((SUM_W > TERR_W) ? SUM_W : TERR_W) + 1;

    logic signed [LERR_W-1:0] r_last_lerr, n_last_lerr;
    logic signed [TERR_W-1:0] r_last_terr, n_last_terr;
    logic signed [SUM_W-1:0]  r_lat_sum,   n_lat_sum;
    logic signed [SUM_W-1:0]  r_turn_sum,  n_turn_sum;
    logic signed [LDER_W-1:0] r_lat_der,   n_lat_der;
    logic signed [TDER_W-1:0] r_turn_der,  n_turn_der;

    logic signed [P:0]        pos_sum;
    logic signed [P+1:0]      pos_adj;
    logic signed [P:0]        pos_diff;
    logic signed [SACC_W-1:0] lat_acc;
    logic signed [SACC_W-1:0] turn_acc;

    function automatic logic signed [SUM_W-1:0] sat_sum(input logic signed [SACC_W-1:0] v);
        logic signed [SUM_W-1:0] res;
        if (v > SACC_W'(SUM_HI)) begin
            res = SUM_HI;
        end else if (v < SACC_W'(SUM_LO)) begin
            res = SUM_LO;
        end else begin
            res = v[SUM_W-1:0];
        end
        return res;
    endfunction

    always_comb begin
        // average truncated toward zero: bias negative sums up by one
        pos_sum  = (P+1)'(i_left_pos) + (P+1)'(i_right_pos);
        pos_adj  = (P+2)'(pos_sum) + $signed({{(P+1){1'b0}}, pos_sum[P]});
        n_last_lerr = pos_adj[P+1:1] - LERR_W'(i_lat_target);

        pos_diff    = (P+1)'(i_left_pos) - (P+1)'(i_right_pos);
        n_last_terr = TERR_W'(pos_diff) - TERR_W'(i_turn_target);

        n_lat_der  = LDER_W'(n_last_lerr) - LDER_W'(r_last_lerr);
        n_turn_der = TDER_W'(n_last_terr) - TDER_W'(r_last_terr);

        lat_acc    = SACC_W'(r_lat_sum) + SACC_W'(n_last_lerr);
        turn_acc   = SACC_W'(r_turn_sum) + SACC_W'(n_last_terr);
        n_lat_sum  = sat_sum(lat_acc);
        n_turn_sum = sat_sum(turn_acc);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_last_lerr <= '0;
            r_last_terr <= '0;
            r_lat_sum   <= '0;
            r_turn_sum  <= '0;
        end else if (i_load) begin
            r_last_lerr <= n_last_lerr;
            r_last_terr <= n_last_terr;
            r_lat_sum   <= n_lat_sum;
            r_turn_sum  <= n_turn_sum;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_lat_der  <= n_lat_der;
            r_turn_der <= n_turn_der;
        end
    end

    // the state registers double as this stage's payload
    assign o_lat_err  = r_last_lerr;
    assign o_lat_der  = r_lat_der;
    assign o_lat_sum  = r_lat_sum;
    assign o_turn_err = r_last_terr;
    assign o_turn_der = r_turn_der;
    assign o_turn_sum = r_turn_sum;

endmodule

// ----- hdl/dpdd_mult.sv -----
// ----------------------------------------------------------------------------
// dpdd_mult
// Product stage: the six gain multiplies, one register each.
// ----------------------------------------------------------------------------
module dpdd_mult
    import dpdd_pkg::*;
#(
    parameter int POSITION_WIDTH = POS_WIDTH_DEF
) (
    input  logic                                  i_clk,
    input  logic                                  i_load,
    input  logic signed [POSITION_WIDTH:0]        i_lat_err,
    input  logic signed [POSITION_WIDTH+1:0]      i_lat_der,
    input  logic signed [SUM_W-1:0]               i_lat_sum,
    input  logic signed [POSITION_WIDTH+1:0]      i_turn_err,
    input  logic signed [POSITION_WIDTH+2:0]      i_turn_der,
    input  logic signed [SUM_W-1:0]               i_turn_sum,
    input  logic signed [GAIN_W-1:0]              i_lat_kp,
    input  logic signed [GAIN_W-1:0]              i_lat_ki,
    input  logic signed [GAIN_W-1:0]              i_lat_kd,
    input  logic signed [GAIN_W-1:0]              i_turn_kp,
    input  logic signed [GAIN_W-1:0]              i_turn_ki,
    input  logic signed [GAIN_W-1:0]              i_turn_kd,
    output logic signed [POSITION_WIDTH+16:0]     o_lat_p,
    output logic signed [POSITION_WIDTH+17:0]     o_lat_d,
    output logic signed [SUM_W+GAIN_W-1:0]        o_lat_i,
    output logic signed [POSITION_WIDTH+17:0]     o_turn_p,
    output logic signed [POSITION_WIDTH+18:0]     o_turn_d,
    output logic signed [SUM_W+GAIN_W-1:0]        o_turn_i
);

    localparam int LP_W = POSITION_WIDTH + 1 + GAIN_W;
    localparam int LD_W = POSITION_WIDTH + 2 + GAIN_W;
    localparam int TP_W = POSITION_WIDTH + 2 + GAIN_W;
    localparam int TD_W = POSITION_WIDTH + 3 + GAIN_W;
    localparam int I_W  = SUM_W + GAIN_W;

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            o_lat_p  <= LP_W'(i_lat_err)  * LP_W'(i_lat_kp);
            o_lat_d  <= LD_W'(i_lat_der)  * LD_W'(i_lat_kd);
            o_lat_i  <= I_W'(i_lat_sum)   * I_W'(i_lat_ki);
            o_turn_p <= TP_W'(i_turn_err) * TP_W'(i_turn_kp);
            o_turn_d <= TD_W'(i_turn_der) * TD_W'(i_turn_kd);
            o_turn_i <= I_W'(i_turn_sum)  * I_W'(i_turn_ki);
        end
    end

endmodule

// ----- hdl/dpdd_mix.sv -----
// ----------------------------------------------------------------------------
// dpdd_mix
// Power and drive stages: term sums, left/right mix, scaling to 1/256 V
// and clamping to the drive limit.
// ----------------------------------------------------------------------------
module dpdd_mix
    import dpdd_pkg::*;
#(
    parameter int POSITION_WIDTH     = POS_WIDTH_DEF,
    parameter int GAIN_FRACTION_BITS = GAIN_FRAC_DEF
) (
    input  logic                                  i_clk,
    input  logic                                  i_load_pow,
    input  logic                                  i_load_out,
    input  logic signed [POSITION_WIDTH+16:0]     i_lat_p,
    input  logic signed [POSITION_WIDTH+17:0]     i_lat_d,
    input  logic signed [SUM_W+GAIN_W-1:0]        i_lat_i,
    input  logic signed [POSITION_WIDTH+17:0]     i_turn_p,
    input  logic signed [POSITION_WIDTH+18:0]     i_turn_d,
    input  logic signed [SUM_W+GAIN_W-1:0]        i_turn_i,
    output logic signed [DRIVE_W-1:0]             o_left_drive,
    output logic signed [DRIVE_W-1:0]             o_right_drive
);

    localparam int TD_W   = POSITION_WIDTH + 3 + GAIN_W;
    localparam int I_W    = SUM_W + GAIN_W;
    localparam int PMAX_W = (TD_W > I_W) ? TD_W : I_W;
    localparam int ACC_W  = PMAX_W + 3;
    localparam int SHR    = (GAIN_FRACTION_BITS >= 8) ? GAIN_FRACTION_BITS - 8 : 0;
    localparam int SHL    = (GAIN_FRACTION_BITS < 8) ? 8 - GAIN_FRACTION_BITS : 0;
    localparam int SCL_W  = ACC_W + SHL;

    logic signed [ACC_W-1:0] r_lat_pow, r_turn_pow;
    logic signed [ACC_W-1:0] n_lat_pow, n_turn_pow;
    logic signed [ACC_W-1:0] left_sum, right_sum;

    // floor shift for extra fraction bits, exact left shift for fewer
    function automatic logic signed [DRIVE_W-1:0] to_drive(input logic signed [ACC_W-1:0] q);
        logic signed [SCL_W-1:0] v;
        logic signed [DRIVE_W-1:0] res;
        v = (SCL_W'(q) <<< SHL) >>> SHR;
        if (v > SCL_W'(DRIVE_LIMIT)) begin
            res = DRIVE_W'(DRIVE_LIMIT);
        end else if (v < -SCL_W'(DRIVE_LIMIT)) begin
            res = -DRIVE_W'(DRIVE_LIMIT);
        end else begin
            res = v[DRIVE_W-1:0];
        end
        return res;
    endfunction

    always_comb begin
        n_lat_pow  = ACC_W'(i_lat_p) + ACC_W'(i_lat_d) + ACC_W'(i_lat_i);
        n_turn_pow = ACC_W'(i_turn_p) + ACC_W'(i_turn_d) + ACC_W'(i_turn_i);
        left_sum   = r_lat_pow + r_turn_pow;
        right_sum  = r_lat_pow - r_turn_pow;
    end

    always_ff @(posedge i_clk) begin
        if (i_load_pow) begin
            r_lat_pow  <= n_lat_pow;
            r_turn_pow <= n_turn_pow;
        end
        if (i_load_out) begin
            o_left_drive  <= to_drive(left_sum);
            o_right_drive <= to_drive(right_sum);
        end
    end

endmodule

// ----- hdl/dual_pid_differential_drive_unit.sv -----
// ----------------------------------------------------------------------------
// dual_pid_differential_drive_unit
// Lateral and turn PID loops on two wheel encoder positions, mixed into
// left and right motor drive levels.
//
//   channel  | direction | handshake               | payload
//   ---------+-----------+-------------------------+-------------------------------
//   input    | in        | i_valid / o_ready       | i_left_position, i_right_position
//   result   | out       | o_valid / i_ready       | o_left_drive, o_right_drive
//   config   | in        | i_cfg_valid/o_cfg_ready | i_cfg_index, i_cfg_data
//
// One word per cycle sustained while i_ready holds; a word passes the input,
// error/state, multiply, term sum and mix/clamp registers before o_valid rises.
// Each stage moves when the next one is empty or moving, so a stalled result
// only holds the stages behind it once they fill up.
// Synchronous active-low reset clears the PID state and valids and resets config.
// Config writes are always taken; write only while the pipeline is empty.
// ----------------------------------------------------------------------------
module dual_pid_differential_drive_unit
    import dpdd_pkg::*;
#(
    parameter int POSITION_WIDTH     = POS_WIDTH_DEF,
    parameter int GAIN_FRACTION_BITS = GAIN_FRAC_DEF
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_valid,
    output logic                              o_ready,
    input  logic signed [POSITION_WIDTH-1:0]  i_left_position,
    input  logic signed [POSITION_WIDTH-1:0]  i_right_position,
    output logic                              o_valid,
    input  logic                              i_ready,
    output logic signed [DRIVE_W-1:0]         o_left_drive,
    output logic signed [DRIVE_W-1:0]         o_right_drive,
    input  logic                              i_cfg_valid,
    output logic                              o_cfg_ready,
    input  logic [CFG_IDX_W-1:0]              i_cfg_index,
    input  logic [POSITION_WIDTH-1:0]         i_cfg_data
);

    localparam int P = POSITION_WIDTH;

    // configuration
    logic signed [GAIN_W-1:0] r_lat_kp, r_lat_ki, r_lat_kd;
    logic signed [GAIN_W-1:0] r_turn_kp, r_turn_ki, r_turn_kd;
    logic signed [P-1:0]      r_lat_tgt, r_turn_tgt;

    // pipeline control
    logic [PIPE_STAGES-1:0] r_valid, n_valid;
    logic [PIPE_STAGES-1:0] stg_rdy;
    logic [PIPE_STAGES-1:0] stg_ld;

    logic signed [P-1:0] r_left_pos, r_right_pos;

    logic signed [P:0]           lat_err;
    logic signed [P+1:0]         lat_der;
    logic signed [SUM_W-1:0]     lat_sum;
    logic signed [P+1:0]         turn_err;
    logic signed [P+2:0]         turn_der;
    logic signed [SUM_W-1:0]     turn_sum;
    logic signed [P+16:0]        lat_p;
    logic signed [P+17:0]        lat_d;
    logic signed [SUM_W+GAIN_W-1:0] lat_i;
    logic signed [P+17:0]        turn_p;
    logic signed [P+18:0]        turn_d;
    logic signed [SUM_W+GAIN_W-1:0] turn_i;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_lat_kp   <= '0;
            r_lat_ki   <= '0;
            r_lat_kd   <= '0;
            r_turn_kp  <= '0;
            r_turn_ki  <= '0;
            r_turn_kd  <= '0;
            r_lat_tgt  <= P'(LAT_TGT_RESET);
            r_turn_tgt <= '0;
        end else if (i_cfg_valid) begin
            case (t_cfg_reg'(i_cfg_index))
                REG_LAT_KP:   r_lat_kp   <= i_cfg_data[GAIN_W-1:0];
                REG_LAT_KI:   r_lat_ki   <= i_cfg_data[GAIN_W-1:0];
                REG_LAT_KD:   r_lat_kd   <= i_cfg_data[GAIN_W-1:0];
                REG_TURN_KP:  r_turn_kp  <= i_cfg_data[GAIN_W-1:0];
                REG_TURN_KI:  r_turn_ki  <= i_cfg_data[GAIN_W-1:0];
                REG_TURN_KD:  r_turn_kd  <= i_cfg_data[GAIN_W-1:0];
                REG_LAT_TGT:  r_lat_tgt  <= i_cfg_data;
                REG_TURN_TGT: r_turn_tgt <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // ready ripples back from the output: a stage can take a word when it is
    // empty or its word moves on this cycle
    always_comb begin
        stg_rdy[STG_OUT] = !r_valid[STG_OUT] || i_ready;
        for (int s = PIPE_STAGES - 2; s >= 0; s--) begin
            stg_rdy[s] = !r_valid[s] || stg_rdy[s+1];
        end
        stg_ld[STG_IN] = i_valid && stg_rdy[STG_IN];
        for (int s = 1; s < PIPE_STAGES; s++) begin
            stg_ld[s] = r_valid[s-1] && stg_rdy[s];
        end
        for (int s = 0; s < PIPE_STAGES - 1; s++) begin
            n_valid[s] = stg_ld[s] || (r_valid[s] && !stg_ld[s+1]);
        end
        n_valid[STG_OUT] = stg_ld[STG_OUT] || (r_valid[STG_OUT] && !i_ready);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
        end else begin
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (stg_ld[STG_IN]) begin
            r_left_pos  <= i_left_position;
            r_right_pos <= i_right_position;
        end
    end

    assign o_ready = stg_rdy[STG_IN];
    assign o_valid = r_valid[STG_OUT];

    dpdd_error #(
        .POSITION_WIDTH (POSITION_WIDTH)
    ) u_error (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_load        (stg_ld[STG_ERR]),
        .i_left_pos    (r_left_pos),
        .i_right_pos   (r_right_pos),
        .i_lat_target  (r_lat_tgt),
        .i_turn_target (r_turn_tgt),
        .o_lat_err     (lat_err),
        .o_lat_der     (lat_der),
        .o_lat_sum     (lat_sum),
        .o_turn_err    (turn_err),
        .o_turn_der    (turn_der),
        .o_turn_sum    (turn_sum)
    );

    dpdd_mult #(
        .POSITION_WIDTH (POSITION_WIDTH)
    ) u_mult (
        .i_clk      (i_clk),
        .i_load     (stg_ld[STG_MUL]),
        .i_lat_err  (lat_err),
        .i_lat_der  (lat_der),
        .i_lat_sum  (lat_sum),
        .i_turn_err (turn_err),
        .i_turn_der (turn_der),
        .i_turn_sum (turn_sum),
        .i_lat_kp   (r_lat_kp),
        .i_lat_ki   (r_lat_ki),
        .i_lat_kd   (r_lat_kd),
        .i_turn_kp  (r_turn_kp),
        .i_turn_ki  (r_turn_ki),
        .i_turn_kd  (r_turn_kd),
        .o_lat_p    (lat_p),
        .o_lat_d    (lat_d),
        .o_lat_i    (lat_i),
        .o_turn_p   (turn_p),
        .o_turn_d   (turn_d),
        .o_turn_i   (turn_i)
    );

    dpdd_mix #(
        .POSITION_WIDTH     (POSITION_WIDTH),
        .GAIN_FRACTION_BITS (GAIN_FRACTION_BITS)
    ) u_mix (
        .i_clk         (i_clk),
        .i_load_pow    (stg_ld[STG_POW]),
        .i_load_out    (stg_ld[STG_OUT]),
        .i_lat_p       (lat_p),
        .i_lat_d       (lat_d),
        .i_lat_i       (lat_i),
        .i_turn_p      (turn_p),
        .i_turn_d      (turn_d),
        .i_turn_i      (turn_i),
        .o_left_drive  (o_left_drive),
        .o_right_drive (o_right_drive)
    );

`ifndef SYNTHESIS
    // an accepted word shows up in the input stage
    a_accept_lands: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && o_ready) |=> r_valid[STG_IN])
        else $error("accepted word missing from input stage");

    // a word in the error stage that cannot move stays put
    a_err_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_valid[STG_ERR] && !stg_ld[STG_MUL]) |=> r_valid[STG_ERR])
        else $error("word dropped from error stage");

    // drive levels stay within the clamp
    a_drive_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_left_drive <= DRIVE_W'(DRIVE_LIMIT)
                  && o_left_drive >= -DRIVE_W'(DRIVE_LIMIT)
                  && o_right_drive <= DRIVE_W'(DRIVE_LIMIT)
                  && o_right_drive >= -DRIVE_W'(DRIVE_LIMIT)))
        else $error("drive level outside limit");
`endif

endmodule
